@@ rtl/pecr_pkg.sv @@
// ----------------------------------------------------------------------------
// pecr_pkg
// Shared types and constants of the calibrated pH / conductivity readout.
// ----------------------------------------------------------------------------
package pecr_pkg;

	// Full-scale converter code. The slope divisor is derived from it.
	localparam int ADC_MAX_CODE = 4095;
	localparam int SLOPE_DIV    = ADC_MAX_CODE * 63;

	// Field widths.
	localparam int SAMPLE_W = 12;
	localparam int OPCODE_W = 3;
	localparam int PH_W     = 31;
	localparam int SLOPE_W  = 26;
	localparam int EC_W     = 36;
	localparam int VREF_W   = 13;
	localparam int ECSOL_W  = 16;
	localparam int SPAN_W   = SAMPLE_W + 1;

	// Configuration port.
	localparam int ADDR_W  = 4;
	localparam int PDATA_W = 32;

	// Multiplier operands: a magnitude of up to 12 bits times up to 16 bits.
	localparam int MUL_A_W = SAMPLE_W;
	localparam int MUL_B_W = ECSOL_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Dividend width. The widest dividend is the slope numerator:
	// |span| * vref_mv < 2^25, shifted left by 18.
	localparam int SLOPE_SHIFT = 18;
	localparam int SLOPE_PROD_W = 25;
	localparam int DVD_W = SLOPE_PROD_W + SLOPE_SHIFT;
	localparam int DVS_W = $clog2(SLOPE_DIV + 1);
	localparam int CNT_W = $clog2(DVD_W);

	// Reset values.
	localparam logic [VREF_W-1:0]   VREF_RST   = VREF_W'(3280);
	localparam logic [ECSOL_W-1:0]  ECSOL_RST  = ECSOL_W'(256);
	localparam logic [SAMPLE_W-1:0] POINT_RST  = SAMPLE_W'(256);

	// Command codes. Six and seven are unused and return an all-zero result.
	typedef enum logic [OPCODE_W-1:0] {
		OP_CAP_LOW  = 3'd0,
		OP_CAP_MID  = 3'd1,
		OP_CAP_HIGH = 3'd2,
		OP_READ_PH  = 3'd3,
		OP_CAP_EC   = 3'd4,
		OP_READ_EC  = 3'd5,
		OP_RSVD6    = 3'd6,
		OP_RSVD7    = 3'd7
	} op_t;

	// Register map, index = byte address / 4.
	typedef enum logic [1:0] {
		REG_VREF     = 2'd0,
		REG_CAL_SIDE = 2'd1,
		REG_EC_SOL   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [VREF_W-1:0]  vref_mv;
		logic               cal_side;
		logic [ECSOL_W-1:0] ec_solution;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
	} div_req_t;

endpackage

@@ rtl/pecr_divider.sv @@
// ----------------------------------------------------------------------------
// pecr_divider
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pecr_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pecr_pkg::div_req_t            req,
	output logic                          done,
	output logic [pecr_pkg::DVD_W-1:0]    quotient
);
	import pecr_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic             fits;
	logic [DVS_W:0]   diff;

	// Bring down the next dividend bit and try to subtract the divisor.
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				dvd_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(DVD_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// Quotient bits shift in from the bottom as dividend bits leave.
				dvd_q <= {dvd_q[DVD_W-2:0], fits};
				rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

@@ rtl/pecr_regs.sv @@
// ----------------------------------------------------------------------------
// pecr_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module pecr_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pecr_pkg::ADDR_W-1:0]    paddr,
	input  logic [pecr_pkg::PDATA_W-1:0]   pwdata,
	output logic [pecr_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output pecr_pkg::cfg_t                 cfg
);
	import pecr_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vref_mv     <= VREF_RST;
			cfg_q.cal_side    <= 1'b0;
			cfg_q.ec_solution <= ECSOL_RST;
		end else if (wr_en) begin
			case (idx)
				REG_VREF:     cfg_q.vref_mv     <= pwdata[VREF_W-1:0];
				REG_CAL_SIDE: cfg_q.cal_side    <= pwdata[0];
				REG_EC_SOL:   cfg_q.ec_solution <= pwdata[ECSOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_VREF:     prdata = PDATA_W'(cfg_q.vref_mv);
			REG_CAL_SIDE: prdata = PDATA_W'(cfg_q.cal_side);
			REG_EC_SOL:   prdata = PDATA_W'(cfg_q.ec_solution);
			default:      prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/ph_ec_calibrated_readout_unit.sv @@
// ----------------------------------------------------------------------------
// ph_ec_calibrated_readout_unit
// Calibrated pH and conductivity readout with a shared iterative divider.
// ----------------------------------------------------------------------------
// Each command transfer yields exactly one result transfer. A command that
// needs a division (any pH capture, a pH reading with a nonzero span, a
// conductivity reading with a nonzero calibration point) passes through the
// sequencer states in order: S_PREP to form the operands, S_MUL for the
// product, S_LOAD to load the divider, S_DIV while the radix-2 divider forms
// 43 quotient bits at one per cycle, S_FIN to apply the sign and saturate,
// and S_OUT to move the result into the output register. Commands without a
// division (conductivity point capture, unused opcodes, division by a zero
// span or point) go from S_PREP straight to S_OUT. The block takes one
// command at a time; in_ready is high only while the sequencer is idle, and a
// finished result sits in its own output register, so the next command can
// be taken while that result still waits for out_ready.
// The slope is span*vref_mv*4/(ADC_MAX_CODE*63) in signed Q16, saturated to
// 26 bits. The pH reading is 7 - 3*(mid-sample)/span in signed Q16, and the
// conductivity reading is sample*ec_solution/ec_point in unsigned Q8. All
// divisions truncate toward zero. Configuration registers (vref_mv at 0x0,
// cal_side at 0x4, ec_solution at 0x8) should be written only while idle.
// ----------------------------------------------------------------------------
module ph_ec_calibrated_readout_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Command channel.
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pecr_pkg::OPCODE_W-1:0]     opcode,
	input  logic [pecr_pkg::SAMPLE_W-1:0]     ph_sample,
	input  logic [pecr_pkg::SAMPLE_W-1:0]     ec_sample,
	// Result channel.
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [pecr_pkg::PH_W-1:0]  ph_value,
	output logic signed [pecr_pkg::SLOPE_W-1:0] slope_value,
	output logic [pecr_pkg::EC_W-1:0]         ec_value,
	output logic                              status,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pecr_pkg::ADDR_W-1:0]       paddr,
	input  logic [pecr_pkg::PDATA_W-1:0]      pwdata,
	output logic [pecr_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);
	import pecr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_MUL,
		S_LOAD,
		S_DIV,
		S_FIN,
		S_OUT
	} state_t;

	localparam logic signed [DVD_W+1:0] PH_SEVEN = (DVD_W+2)'(7 * 65536);
	localparam logic signed [DVD_W+1:0] PH_MAX_W = (DVD_W+2)'(1073741823);
	localparam logic signed [DVD_W+1:0] PH_MIN_W = -(DVD_W+2)'(1073741824);
	localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
	localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

	cfg_t cfg;

	state_t              state_q;
	logic [OPCODE_W-1:0] op_q;
	logic [SAMPLE_W-1:0] phs_q;
	logic [SAMPLE_W-1:0] ecs_q;

	// Calibration state.
	logic [SAMPLE_W-1:0]      low_q;
	logic [SAMPLE_W-1:0]      mid_q;
	logic [SAMPLE_W-1:0]      high_q;
	logic signed [SPAN_W-1:0] span_q;
	logic [SAMPLE_W-1:0]      ecpt_q;

	// Arithmetic operands.
	logic [MUL_A_W-1:0] mul_a_q;
	logic [MUL_B_W-1:0] mul_b_q;
	logic [PROD_W-1:0]  prod_q;
	logic [DVS_W-1:0]   dvs_q;
	logic               neg_q;
	div_req_t           div_req;
	logic               div_done;
	logic [DVD_W-1:0]   quot;

	// Result staging and output registers.
	logic signed [PH_W-1:0]    res_ph_q;
	logic signed [SLOPE_W-1:0] res_slope_q;
	logic [EC_W-1:0]           res_ec_q;
	logic                      res_status_q;
	logic                      out_valid_q;
	logic signed [PH_W-1:0]    out_ph_q;
	logic signed [SLOPE_W-1:0] out_slope_q;
	logic [EC_W-1:0]           out_ec_q;
	logic                      out_status_q;

	logic in_xfer;
	logic out_load;

	// Operand preparation.
	logic signed [SPAN_W-1:0] span_new;
	logic signed [SPAN_W-1:0] span_neg;
	logic [SAMPLE_W-1:0]      span_new_mag;
	logic signed [SPAN_W-1:0] span_old_neg;
	logic [SAMPLE_W-1:0]      span_old_mag;
	logic signed [SPAN_W-1:0] ph_diff;
	logic signed [SPAN_W-1:0] ph_diff_neg;
	logic [SAMPLE_W-1:0]      ph_diff_mag;

	// Final scaling.
	logic [DVD_W:0]             q_ext;
	logic signed [DVD_W+1:0]    q_signed;
	logic signed [DVD_W+1:0]    ph_wide;
	logic signed [PH_W-1:0]     fin_ph;
	logic signed [SLOPE_W-1:0]  fin_slope;
	logic [SLOPE_W-1:0]         q_low_neg;

	pecr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pecr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quot)
	);

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	// A finished result moves into the output register once that register is
	// empty or is being emptied in the same cycle.
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// The span is taken from the points after the capture has landed.
	always_comb begin
		if (cfg.cal_side) begin
			span_new = $signed({1'b0, high_q}) - $signed({1'b0, mid_q});
		end else begin
			span_new = $signed({1'b0, mid_q}) - $signed({1'b0, low_q});
		end
		span_neg     = -span_new;
		span_new_mag = span_new[SPAN_W-1] ? span_neg[SAMPLE_W-1:0] : span_new[SAMPLE_W-1:0];
		span_old_neg = -span_q;
		span_old_mag = span_q[SPAN_W-1] ? span_old_neg[SAMPLE_W-1:0] : span_q[SAMPLE_W-1:0];
		ph_diff      = $signed({1'b0, mid_q}) - $signed({1'b0, phs_q});
		ph_diff_neg  = -ph_diff;
		ph_diff_mag  = ph_diff[SPAN_W-1] ? ph_diff_neg[SAMPLE_W-1:0] : ph_diff[SAMPLE_W-1:0];
	end

	// Dividend alignment per command: Q16 with the slope's extra factor of 4,
	// Q16 for the pH ratio, Q8 for conductivity.
	always_comb begin
		div_req.start   = (state_q == S_LOAD);
		div_req.divisor = dvs_q;
		case (op_q)
			OP_READ_PH: div_req.dividend = DVD_W'({prod_q, 16'b0});
			OP_READ_EC: div_req.dividend = DVD_W'({prod_q, 8'b0});
			default:    div_req.dividend = {prod_q[SLOPE_PROD_W-1:0], {SLOPE_SHIFT{1'b0}}};
		endcase
	end

	// Sign and saturation of the quotient.
	always_comb begin
		q_ext     = {1'b0, quot};
		q_signed  = neg_q ? -$signed({1'b0, q_ext}) : $signed({1'b0, q_ext});
		ph_wide   = PH_SEVEN - q_signed;
		if (ph_wide > PH_MAX_W) begin
			fin_ph = PH_MAX_W[PH_W-1:0];
		end else if (ph_wide < PH_MIN_W) begin
			fin_ph = PH_MIN_W[PH_W-1:0];
		end else begin
			fin_ph = ph_wide[PH_W-1:0];
		end
		q_low_neg = -{1'b0, quot[SLOPE_W-2:0]};
		if (quot[DVD_W-1:SLOPE_W-1] != '0) begin
			fin_slope = neg_q ? SLOPE_MIN : SLOPE_MAX;
		end else if (neg_q) begin
			fin_slope = $signed(q_low_neg);
		end else begin
			fin_slope = $signed({1'b0, quot[SLOPE_W-2:0]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			phs_q        <= '0;
			ecs_q        <= '0;
			low_q        <= POINT_RST;
			mid_q        <= POINT_RST;
			high_q       <= POINT_RST;
			span_q       <= '0;
			ecpt_q       <= POINT_RST;
			mul_a_q      <= '0;
			mul_b_q      <= '0;
			prod_q       <= '0;
			dvs_q        <= '0;
			neg_q        <= 1'b0;
			res_ph_q     <= '0;
			res_slope_q  <= '0;
			res_ec_q     <= '0;
			res_status_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_ph_q     <= '0;
			out_slope_q  <= '0;
			out_ec_q     <= '0;
			out_status_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q  <= opcode;
						phs_q <= ph_sample;
						ecs_q <= ec_sample;
						case (opcode)
							OP_CAP_LOW:  low_q  <= ph_sample;
							OP_CAP_MID:  mid_q  <= ph_sample;
							OP_CAP_HIGH: high_q <= ph_sample;
							OP_CAP_EC:   ecpt_q <= ec_sample;
							default: begin
							end
						endcase
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					res_ph_q     <= '0;
					res_slope_q  <= '0;
					res_ec_q     <= '0;
					res_status_q <= 1'b0;
					state_q      <= S_MUL;
					case (op_q)
						OP_CAP_LOW, OP_CAP_MID, OP_CAP_HIGH: begin
							span_q  <= span_new;
							mul_a_q <= span_new_mag;
							mul_b_q <= MUL_B_W'(cfg.vref_mv);
							neg_q   <= span_new[SPAN_W-1];
							dvs_q   <= DVS_W'(SLOPE_DIV);
						end
						OP_READ_PH: begin
							mul_a_q <= ph_diff_mag;
							mul_b_q <= MUL_B_W'(3);
							neg_q   <= ph_diff[SPAN_W-1] ^ span_q[SPAN_W-1];
							dvs_q   <= DVS_W'(span_old_mag);
							if (span_q == '0) begin
								res_status_q <= 1'b1;
								state_q      <= S_OUT;
							end
						end
						OP_READ_EC: begin
							mul_a_q <= ecs_q;
							mul_b_q <= cfg.ec_solution;
							neg_q   <= 1'b0;
							dvs_q   <= DVS_W'(ecpt_q);
							if (ecpt_q == '0) begin
								res_status_q <= 1'b1;
								state_q      <= S_OUT;
							end
						end
						default: begin
							// Conductivity point capture and unused codes
							// return an all-zero result.
							state_q <= S_OUT;
						end
					endcase
				end
				S_MUL: begin
					prod_q  <= mul_a_q * mul_b_q;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					case (op_q)
						OP_READ_PH: res_ph_q <= fin_ph;
						OP_READ_EC: res_ec_q <= quot[EC_W-1:0];
						default:    res_slope_q <= fin_slope;
					endcase
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_ph_q     <= res_ph_q;
						out_slope_q  <= res_slope_q;
						out_ec_q     <= res_ec_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign ph_value    = out_ph_q;
	assign slope_value = out_slope_q;
	assign ec_value    = out_ec_q;
	assign status      = out_status_q;

endmodule
